// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SCFL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCFL_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SCFL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCFL_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/scfl_pkg.sv =====
// Types, constants and helpers for the size-class free-list allocator.
package scfl_pkg;

  localparam int unsigned HEAP_BYTES_DEF     = 65536;
  localparam int unsigned MIN_BLOCK_LOG2_DEF = 3;
  localparam int unsigned NUM_CLASSES_DEF    = 14;

  localparam int unsigned SIZE_BITS   = 17;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned EXP_BITS    = 5;
  localparam int unsigned BLK_BITS    = 18;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_FREE_IGNORE,
    CMD_OVERSIZE_ALLOC,
    CMD_OVERSIZE_FREE
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FREED     = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_NO_MEMORY = 2'd3
  } status_e;

  typedef enum logic {
    BK_READY,
    BK_POP
  } back_state_e;

  // Classified request as it travels from front to back.
  typedef struct packed {
    cmd_kind_e             kind;
    logic [EXP_BITS-1:0]   exp;
  } cmd_t;

  // Index width for a store of n entries, at least one bit.
  function automatic int unsigned idx_width(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== rtl/core/size_class_free_list_allocator.sv =====
// Top level of the size-class free-list heap allocator.
//
//  port group      dir  handshake                     beat
//  request         in   start / busy                  req_type, request_size, block_address
//  heap_base cfg   in   cfg_valid_i / cfg_ready_o     heap_base
//  result          out  result_valid_o (strobe)       result_address, status, granted_size
//
// A request is classified as it is taken and queued (two entries); the list engine
// takes one queued command per cycle, except that an allocate which pops a list head
// holds the next command off through the head read and the registered next-link RAM read.
// Results are registered and cannot be held off. busy is high while the queue is full.
// Reset empties all class lists, zeroes the bump pointer and heap_base; the next-link
// RAM needs no clearing.
module size_class_free_list_allocator import scfl_pkg::*; #(
  parameter int unsigned HEAP_BYTES     = HEAP_BYTES_DEF,
  parameter int unsigned MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF,
  parameter int unsigned NUM_CLASSES    = NUM_CLASSES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type_i,
  input  logic [SIZE_BITS-1:0] request_size_i,
  input  logic [ADDR_BITS-1:0] block_address_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ADDR_BITS-1:0] heap_base_i,
  output logic                 result_valid_o,
  output logic [ADDR_BITS-1:0] result_address_o,
  output logic [1:0]           status_o,
  output logic [SIZE_BITS-1:0] granted_size_o
);

  localparam int unsigned GRANULES = HEAP_BYTES >> MIN_BLOCK_LOG2;
  localparam int unsigned GW       = idx_width(GRANULES);

  logic [ADDR_BITS-1:0] heap_base_q;
  cmd_t                 f_cmd;
  logic [GW-1:0]        f_gran;
  logic                 q_full;
  logic                 q_valid;
  cmd_t                 q_cmd;
  logic [GW-1:0]        q_gran;
  logic                 q_pop;
  logic                 ram_we;
  logic [GW-1:0]        ram_waddr;
  logic [GW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [GW-1:0]        ram_raddr;
  logic [GW-1:0]        ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      heap_base_q <= heap_base_i;
    end
  end

  scfl_front #(
    .HEAP_BYTES     (HEAP_BYTES),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
    .NUM_CLASSES    (NUM_CLASSES)
  ) u_front (
    .req_type_i      (req_type_i),
    .request_size_i  (request_size_i),
    .block_address_i (block_address_i),
    .heap_base_i     (heap_base_q),
    .cmd_o           (f_cmd),
    .gran_o          (f_gran)
  );

  scfl_queue #(
    .GW (GW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start && !busy),
    .push_cmd_i  (f_cmd),
    .push_gran_i (f_gran),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .cmd_o       (q_cmd),
    .gran_o      (q_gran)
  );

  scfl_ram #(
    .WIDTH (GW),
    .DEPTH (GRANULES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  scfl_back #(
    .HEAP_BYTES     (HEAP_BYTES),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
    .NUM_CLASSES    (NUM_CLASSES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .heap_base_i      (heap_base_q),
    .q_valid_i        (q_valid),
    .q_cmd_i          (q_cmd),
    .q_gran_i         (q_gran),
    .q_pop_o          (q_pop),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .result_valid_o   (result_valid_o),
    .result_address_o (result_address_o),
    .status_o         (status_o),
    .granted_size_o   (granted_size_o)
  );

endmodule

// ===== rtl/core/scfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scfl_ram import scfl_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = idx_width(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/scfl_front.sv =====
// Request classifier: size class, range check and granule index.
module scfl_front import scfl_pkg::*; #(
  parameter int unsigned HEAP_BYTES     = HEAP_BYTES_DEF,
  parameter int unsigned MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF,
  parameter int unsigned NUM_CLASSES    = NUM_CLASSES_DEF,
  localparam int unsigned GRANULES = HEAP_BYTES >> MIN_BLOCK_LOG2,
  localparam int unsigned GW       = idx_width(GRANULES)
) (
  input  logic                 req_type_i,
  input  logic [SIZE_BITS-1:0] request_size_i,
  input  logic [ADDR_BITS-1:0] block_address_i,
  input  logic [ADDR_BITS-1:0] heap_base_i,
  output cmd_t                 cmd_o,
  output logic [GW-1:0]        gran_o
);

  localparam int unsigned EXP_LIMIT = MIN_BLOCK_LOG2 + NUM_CLASSES;

  logic [SIZE_BITS-1:0] size_m1;
  logic [EXP_BITS-1:0]  bit_len;
  logic [EXP_BITS-1:0]  exp;
  logic                 oversize;
  logic [ADDR_BITS:0]   diff;
  logic                 outside;
  logic [ADDR_BITS-1:0] gran_full;

  // zero size counts as one byte
  assign size_m1 = (request_size_i == '0) ? '0 : request_size_i - SIZE_BITS'(1);

  always_comb begin
    bit_len = '0;
    for (int i = 0; i < SIZE_BITS; i++) begin
      if (size_m1[i]) bit_len = EXP_BITS'(i + 1);
    end
  end

  assign exp      = (bit_len < EXP_BITS'(MIN_BLOCK_LOG2)) ? EXP_BITS'(MIN_BLOCK_LOG2) : bit_len;
  assign oversize = (32'(exp) >= EXP_LIMIT);

  assign diff      = {1'b0, block_address_i} - {1'b0, heap_base_i};
  assign outside   = diff[ADDR_BITS] || (diff[ADDR_BITS-1:0] >= ADDR_BITS'(HEAP_BYTES));
  assign gran_full = diff[ADDR_BITS-1:0] >> MIN_BLOCK_LOG2;
  // a partial granule at the heap end wraps to granule zero
  assign gran_o    = (gran_full >= ADDR_BITS'(GRANULES)) ? '0 : GW'(gran_full);

  always_comb begin
    cmd_o.exp = exp;
    if (req_type_i == REQ_ALLOC) begin
      cmd_o.kind = oversize ? CMD_OVERSIZE_ALLOC : CMD_ALLOC;
    end else if (oversize) begin
      cmd_o.kind = CMD_OVERSIZE_FREE;
    end else begin
      cmd_o.kind = outside ? CMD_FREE_IGNORE : CMD_FREE;
    end
  end

endmodule

// ===== rtl/core/scfl_queue.sv =====
// Short command queue between the classifier and the list engine.
module scfl_queue import scfl_pkg::*; #(
  parameter int unsigned GW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          push_cmd_i,
  input  logic [GW-1:0] push_gran_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cmd_t          cmd_o,
  output logic [GW-1:0] gran_o
);

  localparam int unsigned DEPTH = QUEUE_DEPTH;
  localparam int unsigned PW    = idx_width(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  cmd_t          cmd_q  [DEPTH];
  logic [GW-1:0] gran_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = cmd_q[rd_ptr_q];
  assign gran_o  = gran_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wr_ptr_q]  <= push_cmd_i;
      gran_q[wr_ptr_q] <= push_gran_i;
    end
  end

endmodule

// ===== rtl/core/scfl_back.sv =====
// List engine: class heads, bump pointer, next-link RAM access and results.
`include "assert_macros.svh"
module scfl_back import scfl_pkg::*; #(
  parameter int unsigned HEAP_BYTES     = HEAP_BYTES_DEF,
  parameter int unsigned MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF,
  parameter int unsigned NUM_CLASSES    = NUM_CLASSES_DEF,
  localparam int unsigned GRANULES = HEAP_BYTES >> MIN_BLOCK_LOG2,
  localparam int unsigned GW       = idx_width(GRANULES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ADDR_BITS-1:0] heap_base_i,
  input  logic                 q_valid_i,
  input  cmd_t                 q_cmd_i,
  input  logic [GW-1:0]        q_gran_i,
  output logic                 q_pop_o,
  output logic                 ram_we_o,
  output logic [GW-1:0]        ram_waddr_o,
  output logic [GW-1:0]        ram_wdata_o,
  output logic                 ram_re_o,
  output logic [GW-1:0]        ram_raddr_o,
  input  logic [GW-1:0]        ram_rdata_i,
  output logic                 result_valid_o,
  output logic [ADDR_BITS-1:0] result_address_o,
  output logic [1:0]           status_o,
  output logic [SIZE_BITS-1:0] granted_size_o
);

  localparam int unsigned CLW  = $clog2(NUM_CLASSES);
  localparam int unsigned BW   = $clog2(HEAP_BYTES + 1);
  localparam int unsigned SUMW = ((BW > BLK_BITS) ? BW : BLK_BITS) + 1;

  back_state_e          state_q, state_d;
  logic [BW-1:0]        bump_q, bump_d;
  logic [NUM_CLASSES-1:0] hvalid_q, hvalid_d;
  logic [GW-1:0]        head_q [NUM_CLASSES];
  logic [GW-1:0]        head_d [NUM_CLASSES];
  logic [CLW-1:0]       pop_cls_q, pop_cls_d;
  logic [GW-1:0]        pop_head_q, pop_head_d;
  logic [EXP_BITS-1:0]  pop_exp_q, pop_exp_d;
  logic                 res_valid_q, res_valid_d;
  logic [ADDR_BITS-1:0] res_addr_q, res_addr_d;
  status_e              res_status_q, res_status_d;
  logic [SIZE_BITS-1:0] res_size_q, res_size_d;

  logic [CLW-1:0]       cls;
  logic [BLK_BITS-1:0]  blk;
  logic [BLK_BITS-1:0]  pop_blk;
  logic                 cur_valid;
  logic [GW-1:0]        cur_head;
  logic [SUMW-1:0]      bump_sum;
  logic                 fits;

  assign cls       = CLW'(q_cmd_i.exp - EXP_BITS'(MIN_BLOCK_LOG2));
  assign blk       = BLK_BITS'(1) << q_cmd_i.exp;
  assign pop_blk   = BLK_BITS'(1) << pop_exp_q;
  assign cur_valid = hvalid_q[cls];
  assign cur_head  = head_q[cls];
  assign bump_sum  = SUMW'(bump_q) + SUMW'(blk);
  assign fits      = (bump_sum <= SUMW'(HEAP_BYTES));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_READY: begin
        if (q_valid_i && q_cmd_i.kind == CMD_ALLOC && cur_valid) state_d = BK_POP;
      end
      BK_POP:  state_d = BK_READY;
      default: state_d = BK_READY;
    endcase
  end

  // datapath and outputs
  always_comb begin
    bump_d       = bump_q;
    hvalid_d     = hvalid_q;
    head_d       = head_q;
    pop_cls_d    = pop_cls_q;
    pop_head_d   = pop_head_q;
    pop_exp_d    = pop_exp_q;
    res_valid_d  = 1'b0;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    res_size_d   = res_size_q;
    q_pop_o      = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = q_gran_i;
    ram_wdata_o  = cur_head;
    ram_re_o     = 1'b0;
    ram_raddr_o  = cur_head;
    case (state_q)
      BK_READY: begin
        if (q_valid_i) begin
          q_pop_o     = 1'b1;
          res_valid_d = 1'b1;
          res_addr_d  = '0;
          res_size_d  = blk[SIZE_BITS-1:0];
          case (q_cmd_i.kind)
            CMD_ALLOC: begin
              if (cur_valid) begin
                // head pop finishes once the next link is back from RAM
                ram_re_o    = 1'b1;
                pop_cls_d   = cls;
                pop_head_d  = cur_head;
                pop_exp_d   = q_cmd_i.exp;
                res_valid_d = 1'b0;
              end else if (fits) begin
                res_addr_d   = heap_base_i + ADDR_BITS'(bump_q);
                bump_d       = BW'(bump_sum);
                res_status_d = ST_ALLOCATED;
              end else begin
                res_status_d = ST_NO_MEMORY;
              end
            end
            CMD_FREE: begin
              res_status_d = ST_FREED;
              if (!cur_valid) begin
                // first block of a list links to itself
                ram_we_o      = 1'b1;
                ram_wdata_o   = q_gran_i;
                head_d[cls]   = q_gran_i;
                hvalid_d[cls] = 1'b1;
              end else if (cur_head != q_gran_i) begin
                ram_we_o    = 1'b1;
                ram_wdata_o = cur_head;
                head_d[cls] = q_gran_i;
              end
            end
            CMD_FREE_IGNORE: begin
              res_status_d = ST_IGNORED;
            end
            CMD_OVERSIZE_ALLOC: begin
              res_status_d = ST_NO_MEMORY;
              res_size_d   = '0;
            end
            CMD_OVERSIZE_FREE: begin
              res_status_d = ST_IGNORED;
              res_size_d   = '0;
            end
            default: begin
              res_status_d = ST_IGNORED;
              res_size_d   = '0;
            end
          endcase
        end
      end
      BK_POP: begin
        res_valid_d  = 1'b1;
        res_addr_d   = heap_base_i + (ADDR_BITS'(pop_head_q) << MIN_BLOCK_LOG2);
        res_status_d = ST_ALLOCATED;
        res_size_d   = pop_blk[SIZE_BITS-1:0];
        if (ram_rdata_i == pop_head_q) begin
          hvalid_d[pop_cls_q] = 1'b0;
        end else begin
          head_d[pop_cls_q] = ram_rdata_i;
        end
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_READY;
      bump_q      <= '0;
      hvalid_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bump_q      <= bump_d;
      hvalid_q    <= hvalid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q       <= head_d;
    pop_cls_q    <= pop_cls_d;
    pop_head_q   <= pop_head_d;
    pop_exp_q    <= pop_exp_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    res_size_q   <= res_size_d;
  end

  assign result_valid_o   = res_valid_q;
  assign result_address_o = res_addr_q;
  assign status_o         = res_status_q;
  assign granted_size_o   = res_size_q;

  `SCFL_ASSERT(a_pop_gives_result, clk_i, rst_ni, (state_q == BK_POP) |=> res_valid_q, "pop lost its result")
  `SCFL_ASSERT(a_no_deq_in_pop, clk_i, rst_ni, (state_q == BK_POP) |-> !q_pop_o, "queue drained during pop")
  `SCFL_ASSERT(a_read_then_pop, clk_i, rst_ni, ram_re_o |=> (state_q == BK_POP), "link read without pop")
  `SCFL_NEVER(a_ram_rw_clash, clk_i, rst_ni, ram_we_o && ram_re_o, "link RAM read and write together")
  `SCFL_ASSERT(a_bump_in_heap, clk_i, rst_ni, bump_q <= BW'(HEAP_BYTES), "bump pointer past heap end")

endmodule

// ===== sim/size_class_free_list_allocator_checker.sv =====
// Checker for the size-class free-list allocator: predicts each reply and compares it.
`timescale 1ns / 100ps

module size_class_free_list_allocator_checker import scfl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 req_type_i,
  input  logic [SIZE_BITS-1:0] request_size_i,
  input  logic [ADDR_BITS-1:0] block_address_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [ADDR_BITS-1:0] heap_base_i,
  input  logic                 result_valid_i,
  input  logic [ADDR_BITS-1:0] result_address_i,
  input  logic [1:0]           status_i,
  input  logic [SIZE_BITS-1:0] granted_size_i,
  output int                   mismatches_o,
  output int                   outstanding_o
);

  localparam int unsigned GRANULES     = HEAP_BYTES_DEF >> MIN_BLOCK_LOG2_DEF;
  localparam int unsigned GRANULE_BITS = $clog2(GRANULES);

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    status_e              status;
    logic [SIZE_BITS-1:0] size;
  } alloc_reply_t;

  alloc_reply_t            pending_replies[$];
  logic [ADDR_BITS-1:0]    heap_base;
  int unsigned             bump_offset;
  bit                      head_valid [NUM_CLASSES_DEF];
  logic [GRANULE_BITS-1:0] class_head [NUM_CLASSES_DEF];
  logic [GRANULE_BITS-1:0] next_link  [GRANULES];
  int                      mismatch_total = 0;

  assign mismatches_o = mismatch_total;

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_total++;
  endtask

  // Serve one request against the shadow heap and return the reply it should give.
  task automatic serve_request(input logic rtype, input logic [SIZE_BITS-1:0] sz,
                               input logic [ADDR_BITS-1:0] addr, output alloc_reply_t r);
    int unsigned             p;
    int unsigned             cls;
    longint unsigned         want;
    longint unsigned         blk;
    logic [GRANULE_BITS-1:0] h;
    logic [GRANULE_BITS-1:0] nx;
    logic [GRANULE_BITS-1:0] g;
    p = MIN_BLOCK_LOG2_DEF;
    want = (sz == '0) ? 64'd1 : longint'(sz);
    while (p < SIZE_BITS && (64'd1 << p) < want) p++;
    cls = p - MIN_BLOCK_LOG2_DEF;
    blk = 64'd1 << p;
    r.address = '0;
    r.size = '0;
    if (cls >= NUM_CLASSES_DEF) begin
      r.status = (rtype == REQ_FREE) ? ST_IGNORED : ST_NO_MEMORY;
    end else if (rtype == REQ_ALLOC) begin
      r.size = blk[SIZE_BITS-1:0];
      if (head_valid[cls]) begin
        h = class_head[cls];
        nx = next_link[h];
        // a self link marks the tail of the list
        if (nx == h) head_valid[cls] = 1'b0;
        else class_head[cls] = nx;
        r.address = heap_base + (ADDR_BITS'(h) << MIN_BLOCK_LOG2_DEF);
        r.status = ST_ALLOCATED;
      end else if (longint'(bump_offset) + blk > longint'(HEAP_BYTES_DEF)) begin
        r.status = ST_NO_MEMORY;
      end else begin
        r.address = heap_base + ADDR_BITS'(bump_offset);
        bump_offset = bump_offset + int'(blk);
        r.status = ST_ALLOCATED;
      end
    end else begin
      r.size = blk[SIZE_BITS-1:0];
      if (addr < heap_base || (addr - heap_base) >= HEAP_BYTES_DEF) begin
        r.status = ST_IGNORED;
      end else begin
        g = GRANULE_BITS'(((addr - heap_base) >> MIN_BLOCK_LOG2_DEF) % GRANULES);
        if (!head_valid[cls]) begin
          next_link[g] = g;
          class_head[cls] = g;
          head_valid[cls] = 1'b1;
        end else if (class_head[cls] != g) begin
          next_link[g] = class_head[cls];
          class_head[cls] = g;
        end
        r.status = ST_FREED;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_reply_t fresh;
    alloc_reply_t oldest;
    if (!rst_ni) begin
      heap_base = '0;
      bump_offset = 0;
      for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
        head_valid[c] = 1'b0;
        class_head[c] = '0;
      end
      pending_replies.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) heap_base = heap_base_i;
      if (start && !busy) begin
        serve_request(req_type_i, request_size_i, block_address_i, fresh);
        pending_replies.push_back(fresh);
      end
      if (result_valid_i) begin
        if (pending_replies.size() == 0) begin
          flag_mismatch($sformatf("unexpected reply addr=%h status=%0d size=%0d",
                                  result_address_i, status_i, granted_size_i));
        end else begin
          oldest = pending_replies.pop_front();
          if (result_address_i !== oldest.address)
            flag_mismatch($sformatf("result_address got %h want %h",
                                    result_address_i, oldest.address));
          if (status_i !== oldest.status)
            flag_mismatch($sformatf("status got %0d want %0d", status_i, oldest.status));
          if (granted_size_i !== oldest.size)
            flag_mismatch($sformatf("granted_size got %0d want %0d",
                                    granted_size_i, oldest.size));
        end
      end
      outstanding_o <= pending_replies.size();
    end
  end

endmodule

// ===== sim/size_class_free_list_allocator_tb.sv =====
// Testbench top for the size-class free-list allocator: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module size_class_free_list_allocator_tb;
  import scfl_pkg::*;

  typedef struct {
    logic [ADDR_BITS-1:0] off;
    logic [SIZE_BITS-1:0] size;
  } live_block_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 req_type_i = REQ_ALLOC;
  logic [SIZE_BITS-1:0] request_size_i = '0;
  logic [ADDR_BITS-1:0] block_address_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [ADDR_BITS-1:0] heap_base_i = '0;
  logic                 result_valid_o;
  logic [ADDR_BITS-1:0] result_address_o;
  logic [1:0]           status_o;
  logic [SIZE_BITS-1:0] granted_size_o;
  int                   mismatches;
  int                   outstanding;

  live_block_t          live_blocks[$];
  logic [ADDR_BITS-1:0] heap_base_now = '0;
  logic [ADDR_BITS-1:0] last_freed_addr = '0;
  logic [SIZE_BITS-1:0] last_freed_size = 17'd8;
  bit                   quiet = 1'b0;

  always #2 clk_i = ~clk_i;

  size_class_free_list_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .request_size_i  (request_size_i),
    .block_address_i (block_address_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .heap_base_i     (heap_base_i),
    .result_valid_o  (result_valid_o),
    .result_address_o(result_address_o),
    .status_o        (status_o),
    .granted_size_o  (granted_size_o)
  );

  size_class_free_list_allocator_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .request_size_i  (request_size_i),
    .block_address_i (block_address_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .heap_base_i     (heap_base_i),
    .result_valid_i  (result_valid_o),
    .result_address_i(result_address_o),
    .status_i        (status_o),
    .granted_size_i  (granted_size_o),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  // Remember granted blocks so later frees can hand them back.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && status_o == ST_ALLOCATED)
      live_blocks.push_back('{result_address_o - heap_base_now, granted_size_o});
  end

  task automatic issue(input logic rtype, input logic [SIZE_BITS-1:0] sz,
                       input logic [ADDR_BITS-1:0] addr);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(18);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= rtype;
    request_size_i <= sz;
    block_address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold off until every reply is back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic set_heap_base(input logic [ADDR_BITS-1:0] base);
    settle();
    cfg_valid_i <= 1'b1;
    heap_base_i <= base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    heap_base_now = base;
  endtask

  // Mostly small blocks so the bump region lasts; rare huge and oversize ones.
  function automatic logic [SIZE_BITS-1:0] alloc_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) return SIZE_BITS'($urandom_range(64, 1));
    else if (pick < 95) return SIZE_BITS'($urandom_range(512, 65));
    else if (pick < 98) return SIZE_BITS'($urandom_range(8192, 513));
    else if (pick == 98) return SIZE_BITS'($urandom_range(131071, 65536));
    else return '0;
  endfunction

  task automatic random_item();
    int unsigned          pick;
    int unsigned          idx;
    live_block_t          blk;
    logic [SIZE_BITS-1:0] sz;
    pick = $urandom_range(99);
    if (pick < 45 || (pick < 85 && live_blocks.size() == 0)) begin
      issue(REQ_ALLOC, alloc_size(), $urandom);
    end else if (pick < 85) begin
      idx = $urandom_range(live_blocks.size() - 1);
      blk = live_blocks[idx];
      live_blocks.delete(idx);
      // sometimes a different size that still rounds to the same class
      sz = ($urandom_range(3) == 0) ? SIZE_BITS'($urandom_range(blk.size, blk.size / 2 + 1))
                                    : blk.size;
      last_freed_addr = heap_base_now + blk.off;
      last_freed_size = sz;
      issue(REQ_FREE, sz, last_freed_addr);
    end else begin
      case ($urandom_range(3))
        0: issue(REQ_FREE, last_freed_size, last_freed_addr);
        1: begin
          if (live_blocks.size() != 0) begin
            blk = live_blocks[$urandom_range(live_blocks.size() - 1)];
            issue(REQ_FREE, blk.size, heap_base_now + blk.off + $urandom_range(7, 1));
          end else begin
            issue(REQ_FREE, SIZE_BITS'($urandom_range(64)), heap_base_now + $urandom_range(7));
          end
        end
        2: issue(1'($urandom_range(1)), SIZE_BITS'($urandom_range(131071)), $urandom);
        default: begin
          if ($urandom_range(1))
            issue(REQ_FREE, 17'd8, heap_base_now + HEAP_BYTES_DEF + $urandom_range(7));
          else
            issue(REQ_FREE, 17'd8, heap_base_now - $urandom_range(8, 1));
        end
      endcase
    end
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(3) == 0);
      if ($urandom_range(149) == 0) settle();
      random_item();
    end
    quiet = 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned wait_cycles;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_heap_base(32'h0000_0000);
    issue(REQ_ALLOC, 17'd0, 32'h0000_0000);
    issue(REQ_ALLOC, 17'd1, 32'hFFFF_FFFF);
    issue(REQ_ALLOC, 17'd9, 32'h0000_0000);
    issue(REQ_ALLOC, 17'h10000, 32'h0000_0000);      // full heap no longer fits
    issue(REQ_ALLOC, 17'h10001, 32'h0000_0000);      // oversize
    issue(REQ_ALLOC, 17'h1FFFF, 32'h0000_0000);
    issue(REQ_FREE, 17'h1FFFF, 32'h0000_0000);
    issue(REQ_FREE, 17'd8, 32'h0000_0008);
    issue(REQ_FREE, 17'd8, 32'h0000_0008);           // already the head
    issue(REQ_FREE, 17'd1, 32'h0000_0000);
    issue(REQ_FREE, 17'd16, 32'h0000_0013);          // misaligned
    issue(REQ_FREE, 17'd8, 32'h0001_0000);           // one past the heap end
    issue(REQ_FREE, 17'd8, 32'hFFFF_FFFF);
    issue(REQ_FREE, 17'd8, 32'h0000_0008);           // closes a cycle in the list
    repeat (3) issue(REQ_ALLOC, 17'd4, 32'h0000_0000);
    issue(REQ_ALLOC, 17'd16, 32'h0000_0000);
    issue(REQ_ALLOC, 17'd16, 32'h0000_0000);
    issue(REQ_FREE, 17'h10000, 32'h0000_0000);
    issue(REQ_ALLOC, 17'h10000, 32'h0000_0000);
    issue(REQ_FREE, 17'hFFFF, 32'h0000_FFFF);
    run_random(300);

    set_heap_base(32'hFFFF_0000);
    issue(REQ_FREE, 17'd64, 32'hFFFF_FFFF);
    issue(REQ_FREE, 17'd8, 32'hFFFE_FFFF);
    issue(REQ_ALLOC, 17'd64, 32'h0000_0000);
    run_random(300);

    set_heap_base($urandom & 32'hFFFF_FFF8);
    run_random(300);

    set_heap_base(32'hFFFF_FFF8);
    issue(REQ_FREE, 17'd8, 32'hFFFF_FFF8);
    issue(REQ_ALLOC, 17'd8, 32'h0000_0000);
    run_random(100);

    // drain the bump region in descending powers so it can end flush with the heap
    set_heap_base(32'h0000_1000);
    for (int pass = 0; pass < 3; pass++)
      for (int p = 16; p >= 3; p--)
        issue(REQ_ALLOC, SIZE_BITS'(1 << p), $urandom);

    start <= 1'b0;
    wait_cycles = 0;
    @(posedge clk_i);
    while (outstanding != 0 && wait_cycles < 1000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
